// ----- src/gbe_pkg.sv -----
`default_nettype none
package gbe_pkg;

   // exp() table: top fraction bits pick a product of roots of one half
   localparam int EXP_TABLE_BITS = 6;
   localparam int TAB_N          = 1 << EXP_TABLE_BITS;
   localparam int G_W            = 32 - EXP_TABLE_BITS;   // remaining fraction
   localparam int XX_W           = 2 * G_W;
   localparam int XH_W           = XX_W - 32;
   localparam int C_W            = XH_W + G_W;
   localparam int V_W            = C_W - 32;

   // floor(v / 6) as (v * DIV6_MUL) >> DIV6_SH, exact for v < 2^23
   localparam int DIV6_SH  = 24;
   localparam int DIV6_W   = 22;
   localparam int DIV6_MUL = 2796203;

   localparam logic [31:0] LOG2E_Q31 = 32'hB8AA3B29;
   localparam logic [31:0] LN2_Q32   = 32'hB17217F8;

   localparam int T_W   = 58;     // alpha * r2 in Q.48, below 1024
   localparam int K_W   = 11;     // integer part of t * log2(e)
   localparam int MAN_W = 33;     // exp mantissa, up to 1.0 in Q.32
   localparam int E_W   = 11;     // monomial binary exponent
   localparam int SH_W  = 13;     // final shift count
   localparam int STEP_W = 5;

   // pipeline layout
   localparam int MONO_STEPS = 21;                // 3 axes * up to 7 factors
   localparam int MONO_END   = 2 + MONO_STEPS;    // stage holding finished monomial
   localparam int T_STAGE    = 5;                 // stage holding t48
   localparam int EXP_STAGE  = T_STAGE + 7;       // stage holding exp mantissa
   localparam int SB_DLY     = MONO_END - T_STAGE;
   localparam int EXP_DLY    = MONO_END - EXP_STAGE;
   localparam int LAT        = MONO_END + 3;

   typedef enum logic [2:0] {
      CSR_POWER_X     = 3'd0,
      CSR_POWER_Y     = 3'd1,
      CSR_POWER_Z     = 3'd2,
      CSR_WIDTH_COEFF = 3'd3,
      CSR_CENTER_X    = 3'd4,
      CSR_CENTER_Y    = 3'd5,
      CSR_CENTER_Z    = 3'd6
   } csr_idx_type;

   typedef logic [TAB_N-1:0][MAN_W-1:0] tab_type;

   // one normalized axis factor: mantissa with bit 31 set, and its bit length
   typedef struct packed {
      logic [31:0] an;
      logic [5:0]  bl;
   } fac_type;

   typedef struct packed {
      logic [31:0]           m;
      logic signed [E_W-1:0] e;
      fac_type               fx;
      fac_type               fy;
      fac_type               fz;
   } mono_type;

   typedef struct packed {
      logic [2:0] px;
      logic [2:0] py;
      logic [2:0] pz;
   } pow_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } sb_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int n = 0; n < 32; n++) begin
         if (b > v) b = b >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic tab_type build_tab();
      logic [63:0]  roots [EXP_TABLE_BITS];
      logic [127:0] pr;
      logic [63:0]  acc;
      tab_type      t;
      roots[0] = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 1; j < EXP_TABLE_BITS; j++) begin
         roots[j] = isqrt64(roots[j-1] << 32);
      end
      for (int i = 0; i < TAB_N; i++) begin
         acc = 64'h1_0000_0000;
         for (int j = 0; j < EXP_TABLE_BITS; j++) begin
            if (((i >> (EXP_TABLE_BITS - 1 - j)) & 1) != 0) begin
               pr  = {64'd0, acc} * {64'd0, roots[j]};
               acc = pr[95:32];
            end
         end
         t[i] = acc[MAN_W-1:0];
      end
      return t;
   endfunction

   localparam tab_type EXP_TAB = build_tab();

endpackage
`default_nettype wire

// ----- src/gbe_mono_step.sv -----
`default_nettype none
// One factor of the monomial: multiply, renormalize to 32 bits, track exponent.
module gbe_mono_step (
   input  logic                         clock,
   input  logic [gbe_pkg::STEP_W-1:0]   step,
   input  gbe_pkg::pow_type             pw,
   input  gbe_pkg::mono_type            src_mono,
   output gbe_pkg::mono_type            dst_mono
);
   import gbe_pkg::*;

   logic [STEP_W-1:0] lim_x;
   logic [STEP_W-1:0] lim_xy;
   logic [STEP_W-1:0] lim_xyz;
   fac_type           fac;
   logic              use_f;
   logic [63:0]       prod;
   mono_type          mono_ff;
   mono_type          mono_in;

   // factors go x first, then y, then z
   always_comb begin
      lim_x   = {2'b00, pw.px};
      lim_xy  = lim_x + {2'b00, pw.py};
      lim_xyz = lim_xy + {2'b00, pw.pz};
      use_f   = 1'b1;
      fac     = src_mono.fx;
      if (step < lim_x) begin
         fac = src_mono.fx;
      end else if (step < lim_xy) begin
         fac = src_mono.fy;
      end else if (step < lim_xyz) begin
         fac = src_mono.fz;
      end else begin
         use_f = 1'b0;
      end
   end

   // both operands normalized: product lies in [2^62, 2^64)
   always_comb begin
      prod    = {32'd0, src_mono.m} * {32'd0, fac.an};
      mono_in = src_mono;
      if (use_f) begin
         mono_in.m = prod[63] ? prod[63:32] : prod[62:31];
         mono_in.e = src_mono.e
                   + $signed({{(E_W-6){1'b0}}, fac.bl})
                   + $signed({{(E_W-1){1'b0}}, prod[63]})
                   - E_W'(17);
      end
   end

   always_ff @(posedge clock) begin
      mono_ff <= mono_in;
   end

   assign dst_mono = mono_ff;

endmodule
`default_nettype wire

// ----- src/gbe_exp.sv -----
`default_nettype none
// exp(-t) = mant * 2^-32 * 2^-k, seven register stages
module gbe_exp (
   input  logic                         clock,
   input  logic [gbe_pkg::T_W-1:0]      t48,
   output logic [gbe_pkg::MAN_W-1:0]    mant,
   output logic [gbe_pkg::K_W-1:0]      k
);
   import gbe_pkg::*;

   logic [41:0]               a;
   logic [63:0]               pl_ff, pl_in;
   logic [41:0]               ph_ff, ph_in;
   logic [73:0]               full;
   logic [42:0]               u;
   logic [K_W-1:0]            k2_ff, k2_in, k3_ff, k4_ff, k5_ff, k6_ff, k7_ff;
   logic [EXP_TABLE_BITS-1:0] idx_ff, idx_in;
   logic [G_W-1:0]            g_ff, g_in;
   logic [MAN_W-1:0]          tab3_ff, tab3_in, tab4_ff, tab5_ff, tab6_ff;
   logic [G_W+31:0]           xm;
   logic [G_W-1:0]            x3_ff, x3_in, x4_ff;
   logic [XX_W-1:0]           xx_ff, xx_in;
   logic [C_W-1:0]            c_ff, c_in;
   logic [MAN_W-1:0]          pa_ff, pa_in;
   logic [V_W+DIV6_W-1:0]     q6p;
   logic [MAN_W-1:0]          p_ff, p_in;
   logic [2*MAN_W-1:0]        mp;
   logic [MAN_W-1:0]          mant_ff, mant_in;

   // stage 1: t * log2(e), split in two partial products
   always_comb begin
      a     = t48[T_W-1:16];
      pl_in = {32'd0, a[31:0]} * {32'd0, LOG2E_Q31};
      ph_in = {32'd0, a[41:32]} * {10'd0, LOG2E_Q31};
   end

   // stage 2: integer part, table index and residual fraction
   always_comb begin
      full   = {10'd0, pl_ff} + {ph_ff, 32'd0};
      u      = full[73:31];
      k2_in  = u[42:32];
      idx_in = u[31:G_W];
      g_in   = u[G_W-1:0];
   end

   // stage 3: table lookup, residual times ln2
   always_comb begin
      tab3_in = EXP_TAB[idx_ff];
      xm      = {32'd0, g_ff} * {{G_W{1'b0}}, LN2_Q32};
      x3_in   = xm[G_W+31:32];
   end

   // stage 4..6: cubic polynomial for exp(-x)
   always_comb begin
      xx_in = {{G_W{1'b0}}, x3_ff} * {{G_W{1'b0}}, x3_ff};
      c_in  = {{G_W{1'b0}}, xx_ff[XX_W-1:32]} * {{XH_W{1'b0}}, x4_ff};
      pa_in = 33'h1_0000_0000 - MAN_W'(x4_ff) + MAN_W'(xx_ff >> 33);
      q6p   = {{DIV6_W{1'b0}}, c_ff[C_W-1:32]} * {{V_W{1'b0}}, DIV6_W'(DIV6_MUL)};
      p_in  = pa_ff - MAN_W'(q6p >> DIV6_SH);
   end

   // stage 7: table value times polynomial
   always_comb begin
      mp      = {{MAN_W{1'b0}}, tab6_ff} * {{MAN_W{1'b0}}, p_ff};
      mant_in = mp[MAN_W+31:32];
   end

   always_ff @(posedge clock) begin
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      k2_ff   <= k2_in;
      idx_ff  <= idx_in;
      g_ff    <= g_in;
      k3_ff   <= k2_ff;
      tab3_ff <= tab3_in;
      x3_ff   <= x3_in;
      k4_ff   <= k3_ff;
      tab4_ff <= tab3_ff;
      x4_ff   <= x3_ff;
      xx_ff   <= xx_in;
      k5_ff   <= k4_ff;
      tab5_ff <= tab4_ff;
      c_ff    <= c_in;
      pa_ff   <= pa_in;
      k6_ff   <= k5_ff;
      tab6_ff <= tab5_ff;
      p_ff    <= p_in;
      k7_ff   <= k6_ff;
      mant_ff <= mant_in;
   end

   assign mant = mant_ff;
   assign k    = k7_ff;

endmodule
`default_nettype wire

// ----- src/gaussian_basis_evaluate.sv -----
`default_nettype none
// Cartesian Gaussian primitive evaluator. One grid point is taken per clock
// (busy is high only while reset is held) and its value appears on
// rsp_basis_value with rsp_valid once the point has passed every stage;
// results come out in order and cannot be held off by the receiver.
// The depth is set by the monomial chain: one multiply-and-normalize stage
// for each of the up to 21 factors, after two stages of offset and square
// setup, then three stages of scaling and saturation. The exp unit runs in
// parallel and is delayed to meet the chain. Registers are written through
// csr_we/csr_index/csr_wdata and should only change while no item is in flight.
module gaussian_basis_evaluate (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   output logic signed [47:0] rsp_basis_value,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import gbe_pkg::*;

   // configuration registers
   logic [2:0]  power_x_ff, power_y_ff, power_z_ff;
   logic [31:0] width_coeff_ff;
   logic [31:0] center_x_ff, center_y_ff, center_z_ff;
   pow_type     pw;

   logic [LAT-1:0] vld_ff, vld_in;

   logic [32:0] dx, dy, dz;
   logic [31:0] adx_in, ady_in, adz_in;
   logic [31:0] adx_ff, ady_ff, adz_ff;
   sb_type      sb1_ff, sb1_in, sb2_ff, sb3_ff, sb3_in, sb4_ff, sb5_ff, sb5_in;

   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   fac_type     fx_in, fy_in, fz_in;
   mono_type    mono2_ff, mono2_in;
   mono_type    mono_chain [MONO_STEPS+1];

   logic [65:0] r2sum;
   logic [63:0] r2_ff;
   logic [63:0] apl_ff, aph_ff;
   logic [95:0] tfull;
   logic [T_W-1:0] t48_ff;

   sb_type         sb_dly_ff [SB_DLY];
   logic [MAN_W-1:0] mant_e;
   logic [K_W-1:0]   k_e;
   logic [MAN_W-1:0] mant_dly_ff [EXP_DLY];
   logic [K_W-1:0]   k_dly_ff [EXP_DLY];

   logic [64:0]            qprod;
   logic [63:0]            q_ff;
   logic signed [SH_W-1:0] sh_ff, sh_in;
   sb_type                 sb24_ff, sb25_ff;
   logic [63:0]            mag_ff, mag_in;
   logic [SH_W-1:0]        nsh;
   logic [5:0]             shl;
   logic [63:0]            chk;
   logic [63:0]            lim;
   logic [47:0]            res_ff, res_in;

   assign busy = reset;
   assign pw   = '{px: power_x_ff, py: power_y_ff, pz: power_z_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         power_x_ff     <= '0;
         power_y_ff     <= '0;
         power_z_ff     <= '0;
         width_coeff_ff <= 32'h0001_0000;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         center_z_ff    <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_POWER_X:     power_x_ff     <= csr_wdata[2:0];
            CSR_POWER_Y:     power_y_ff     <= csr_wdata[2:0];
            CSR_POWER_Z:     power_z_ff     <= csr_wdata[2:0];
            CSR_WIDTH_COEFF: width_coeff_ff <= csr_wdata;
            CSR_CENTER_X:    center_x_ff    <= csr_wdata;
            CSR_CENTER_Y:    center_y_ff    <= csr_wdata;
            CSR_CENTER_Z:    center_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits, one per stage
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: offsets, their magnitudes, sign of the result, zero base
   always_comb begin
      dx = {req_pos_x[31], req_pos_x} - {center_x_ff[31], center_x_ff};
      dy = {req_pos_y[31], req_pos_y} - {center_y_ff[31], center_y_ff};
      dz = {req_pos_z[31], req_pos_z} - {center_z_ff[31], center_z_ff};
      adx_in = dx[32] ? 32'(-dx) : dx[31:0];
      ady_in = dy[32] ? 32'(-dy) : dy[31:0];
      adz_in = dz[32] ? 32'(-dz) : dz[31:0];
      sb1_in.neg  = (dx[32] & power_x_ff[0]) ^ (dy[32] & power_y_ff[0])
                  ^ (dz[32] & power_z_ff[0]);
      sb1_in.zero = (adx_in == 32'd0 && power_x_ff != 3'd0)
                  || (ady_in == 32'd0 && power_y_ff != 3'd0)
                  || (adz_in == 32'd0 && power_z_ff != 3'd0);
   end

   // stage 2: squares, normalized factors for the monomial chain
   always_comb begin
      fx_in.bl = '0;
      fy_in.bl = '0;
      fz_in.bl = '0;
      for (int i = 0; i < 32; i++) begin
         if (adx_ff[i]) fx_in.bl = 6'(i + 1);
         if (ady_ff[i]) fy_in.bl = 6'(i + 1);
         if (adz_ff[i]) fz_in.bl = 6'(i + 1);
      end
      fx_in.an = adx_ff << (6'd32 - fx_in.bl);
      fy_in.an = ady_ff << (6'd32 - fy_in.bl);
      fz_in.an = adz_ff << (6'd32 - fz_in.bl);
      mono2_in.m  = 32'h8000_0000;
      mono2_in.e  = E_W'(-31);
      mono2_in.fx = fx_in;
      mono2_in.fy = fy_in;
      mono2_in.fz = fz_in;
   end

   // stage 3: r2, overflow counts only when alpha is nonzero
   always_comb begin
      r2sum = {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
      sb3_in      = sb2_ff;
      sb3_in.zero = sb2_ff.zero
                  | ((r2sum[65:64] != 2'b00) && (width_coeff_ff != 32'd0));
   end

   // stage 5: t = alpha * r2, large argument gives zero
   always_comb begin
      tfull       = {32'd0, apl_ff} + {aph_ff, 32'd0};
      sb5_in      = sb4_ff;
      sb5_in.zero = sb4_ff.zero | (tfull[95:T_W] != '0);
   end

   always_ff @(posedge clock) begin
      adx_ff   <= adx_in;
      ady_ff   <= ady_in;
      adz_ff   <= adz_in;
      sb1_ff   <= sb1_in;
      sqx_ff   <= {32'd0, adx_ff} * {32'd0, adx_ff};
      sqy_ff   <= {32'd0, ady_ff} * {32'd0, ady_ff};
      sqz_ff   <= {32'd0, adz_ff} * {32'd0, adz_ff};
      mono2_ff <= mono2_in;
      sb2_ff   <= sb1_ff;
      r2_ff    <= r2sum[63:0];
      sb3_ff   <= sb3_in;
      apl_ff   <= {32'd0, width_coeff_ff} * {32'd0, r2_ff[31:0]};
      aph_ff   <= {32'd0, width_coeff_ff} * {32'd0, r2_ff[63:32]};
      sb4_ff   <= sb3_ff;
      t48_ff   <= tfull[T_W-1:0];
      sb5_ff   <= sb5_in;
   end

   // monomial chain, at most one factor per stage
   assign mono_chain[0] = mono2_ff;

   for (genvar g = 0; g < MONO_STEPS; g++) begin : g_mono
      gbe_mono_step u_step (
         .clock    (clock),
         .step     (STEP_W'(g)),
         .pw       (pw),
         .src_mono (mono_chain[g]),
         .dst_mono (mono_chain[g+1])
      );
   end

   gbe_exp u_exp (
      .clock (clock),
      .t48   (t48_ff),
      .mant  (mant_e),
      .k     (k_e)
   );

   // align flags and exp result with the end of the monomial chain
   always_ff @(posedge clock) begin
      sb_dly_ff[0]   <= sb5_ff;
      mant_dly_ff[0] <= mant_e;
      k_dly_ff[0]    <= k_e;
      for (int i = 1; i < SB_DLY; i++) begin
         sb_dly_ff[i] <= sb_dly_ff[i-1];
      end
      for (int i = 1; i < EXP_DLY; i++) begin
         mant_dly_ff[i] <= mant_dly_ff[i-1];
         k_dly_ff[i]    <= k_dly_ff[i-1];
      end
   end

   // stage 24: monomial times exp mantissa, net shift
   always_comb begin
      qprod = {33'd0, mono_chain[MONO_STEPS].m}
            * {32'd0, mant_dly_ff[EXP_DLY-1]};
      sh_in = $signed({{(SH_W-E_W){mono_chain[MONO_STEPS].e[E_W-1]}},
                       mono_chain[MONO_STEPS].e})
            - $signed({{(SH_W-K_W){1'b0}}, k_dly_ff[EXP_DLY-1]});
   end

   // stage 25: scale by 2^sh, saturate on the way up
   always_comb begin
      mag_in = '0;
      nsh    = SH_W'(-sh_ff);
      shl    = sh_ff[5:0];
      chk    = '0;
      if (q_ff != 64'd0) begin
         if (!sh_ff[SH_W-1]) begin
            if (sh_ff >= SH_W'(47)) begin
               mag_in = 64'd1 << 47;
            end else begin
               chk = q_ff >> (6'd47 - shl);
               if (chk != 64'd0) mag_in = 64'd1 << 47;
               else mag_in = q_ff << shl;
            end
         end else if (nsh < SH_W'(64)) begin
            mag_in = q_ff >> nsh[5:0];
         end
      end
   end

   // stage 26: clamp, apply sign
   always_comb begin
      lim    = '0;
      res_in = '0;
      if (!sb25_ff.zero) begin
         if (sb25_ff.neg) begin
            lim    = (mag_ff > (64'd1 << 47)) ? (64'd1 << 47) : mag_ff;
            res_in = 48'(-lim);
         end else begin
            lim    = (mag_ff > ((64'd1 << 47) - 64'd1)) ? ((64'd1 << 47) - 64'd1)
                                                       : mag_ff;
            res_in = lim[47:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= qprod[63:0];
      sh_ff   <= sh_in;
      sb24_ff <= sb_dly_ff[SB_DLY-1];
      mag_ff  <= mag_in;
      sb25_ff <= sb24_ff;
      res_ff  <= res_in;
   end

   assign rsp_valid       = vld_ff[LAT-1];
   assign rsp_basis_value = res_ff;

   // every item taken gives a result a fixed latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("item lost in pipeline");

   // no result without an item taken at the right time
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without item");

   // monomial stays normalized unless a zero base forces a zero result
   a_mono_norm: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[MONO_END-1] && !sb_dly_ff[SB_DLY-1].zero)
         |-> mono_chain[MONO_STEPS].m[31])
      else $error("monomial mantissa lost normalization");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
   import gbe_pkg::*;

   localparam logic [2:0] CSR_SPARE = 3'd7;     // no register behind this index
   localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic               rsp_valid;
   logic signed [47:0] rsp_basis_value;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   gaussian_basis_evaluate dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_basis_value(rsp_basis_value),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow copy of the block's registers
   logic [2:0]  pow_x, pow_y, pow_z;
   logic [31:0] alpha;
   logic [31:0] cen_x, cen_y, cen_z;

   logic [63:0] half_roots [EXP_TABLE_BITS];
   logic [47:0] pending_values [$];
   int          errors = 0;
   bit          long_gaps = 1'b1;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= {64'd0, v}) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   function automatic int bit_length(input logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   // exp(-t/2^48) as mant * 2^-32 * 2^-k
   function automatic void exp_decay(input logic [63:0] t48, output logic [63:0] mant,
                                     output int k);
      logic [127:0] u128;
      logic [63:0]  u, f, idx, g, x, xx, p, tab;
      u128 = {64'd0, t48 >> 16} * {96'd0, LOG2E_Q31};
      u    = u128[94:31];
      k    = int'(u >> 32);
      f    = u & 64'hFFFF_FFFF;
      idx  = f >> (32 - EXP_TABLE_BITS);
      g    = f & ((64'd1 << (32 - EXP_TABLE_BITS)) - 1);
      tab  = 64'h1_0000_0000;
      for (int j = 0; j < EXP_TABLE_BITS; j++)
         if (idx[EXP_TABLE_BITS-1-j]) tab = mul_q32(tab, half_roots[j]);
      x  = (g * {32'd0, LN2_Q32}) >> 32;
      xx = x * x;
      p  = 64'h1_0000_0000 - x + (xx >> 33) - (((xx >> 32) * x) >> 32) / 64'd6;
      mant = mul_q32(tab, p);
   endfunction

   // value of the primitive at one grid point under the current registers
   function automatic logic [47:0] basis_at(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz);
      logic [31:0]  pos [3];
      logic [31:0]  cen [3];
      logic [2:0]   pw [3];
      logic [63:0]  ad [3];
      longint       d;
      logic [127:0] r2, t;
      logic [63:0]  mant, m, prod, q, mag;
      bit           neg;
      int           k, e, bl, sh;
      pos = '{px, py, pz};
      cen = '{cen_x, cen_y, cen_z};
      pw  = '{pow_x, pow_y, pow_z};
      neg = 1'b0;
      r2  = '0;
      for (int i = 0; i < 3; i++) begin
         d = longint'(signed'(pos[i])) - longint'(signed'(cen[i]));
         ad[i] = (d < 0) ? 64'(-d) : 64'(d);
         if (d < 0 && pw[i][0]) neg = !neg;
         if (ad[i] == 0 && pw[i] != 0) return '0;   // zero base
         r2 = r2 + {64'd0, ad[i] * ad[i]};
      end
      if (r2[127:64] != 0 && alpha != 0) return '0;
      t = {96'd0, alpha} * {64'd0, r2[63:0]};
      if (t >= (128'd1 << 58)) return '0;           // exp underflows
      exp_decay(t[63:0], mant, k);
      // monomial as normalized 32-bit mantissa and binary exponent
      m = 64'h8000_0000;
      e = -31;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < pw[i]; c++) begin
            prod = m * ad[i];
            e -= 16;
            bl = bit_length(prod);
            if (bl > 32) begin
               prod = prod >> (bl - 32);
               e += bl - 32;
            end else if (bl < 32) begin
               prod = prod << (32 - bl);
               e -= 32 - bl;
            end
            m = prod;
         end
      end
      q  = m * mant;
      sh = e - k;
      if (q == 0) mag = 0;
      else if (sh >= 0) begin
         if (sh >= 47 || q > (64'h7FFF_FFFF_FFFF >> sh)) mag = 64'd1 << 47;
         else mag = q << sh;
      end else mag = (-sh >= 64) ? 64'd0 : (q >> (-sh));
      if (neg) begin
         if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
         return 48'(~mag + 64'd1);
      end
      if (mag > 64'h7FFF_FFFF_FFFF) mag = 64'h7FFF_FFFF_FFFF;
      return mag[47:0];
   endfunction

   // register write, shadowed into the predictor
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_POWER_X:     pow_x = val[2:0];
         CSR_POWER_Y:     pow_y = val[2:0];
         CSR_POWER_Z:     pow_z = val[2:0];
         CSR_WIDTH_COEFF: alpha = val;
         CSR_CENTER_X:    cen_x = val;
         CSR_CENTER_Y:    cen_y = val;
         CSR_CENTER_Z:    cen_z = val;
         default: ;
      endcase
   endtask

   // stop offering items, then let the pipeline empty
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      n = 0;
      if (long_gaps) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            9:             n = $urandom_range(8, 30);
            default:       n = $urandom_range(1, 3);
         endcase
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // offer one grid point; start stays high for a following item unless an idle gap drops it
   task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
      start     <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_values.push_back(basis_at(px, py, pz));
      idle_gap();
   endtask

   function automatic logic [31:0] near_offset();
      logic [31:0] v;
      v = $urandom() >> $urandom_range(8, 31);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [31:0] pick_alpha();
      case ($urandom_range(0, 6))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h0001_0000;
         default: return $urandom() >> $urandom_range(8, 31);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected basis_value %h", $realtime, rsp_basis_value);
            errors++;
         end else begin
            if (rsp_basis_value !== pending_values[0]) begin
               $display("%0t: basis_value expected %h actual %h", $realtime,
                        pending_values[0], rsp_basis_value);
               errors++;
            end
            void'(pending_values.pop_front());
         end
      end
   end

   task automatic test_corner_points();
      send_point(32'd0, 32'd0, 32'd0);                       // exp(0) = 1
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_point(32'h0028_0000, 32'd0, 32'd0);               // large argument
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_zero_base();
      write_reg(CSR_POWER_X, 32'd7);
      write_reg(CSR_POWER_Y, 32'hFFFF_FFFA);   // upper bits dropped
      write_reg(CSR_POWER_Z, 32'd1);
      send_point(32'd0, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h0001_0000, 32'h0001_0000, 32'd0);
      send_point(32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_0000);
      wait_drained();
   endtask

   task automatic test_saturation();
      write_reg(CSR_WIDTH_COEFF, 32'd0);
      write_reg(CSR_POWER_X, 32'd7);
      write_reg(CSR_POWER_Y, 32'd7);
      write_reg(CSR_POWER_Z, 32'd7);
      write_reg(CSR_CENTER_X, 32'h7FFF_FFFF);
      write_reg(CSR_CENTER_Y, 32'h8000_0000);
      write_reg(CSR_CENTER_Z, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0001);
      send_point(32'h7FFF_0000, 32'h8001_0000, 32'hFFFF_0000);
      wait_drained();
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);     // must be ignored
      write_reg(CSR_WIDTH_COEFF, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      wait_drained();
   endtask

   // random register settings, each with a batch of grid points mostly around the center
   task automatic test_random_phases();
      for (int ph = 0; ph < 16; ph++) begin
         write_reg(CSR_POWER_X, $urandom());
         write_reg(CSR_POWER_Y, $urandom());
         write_reg(CSR_POWER_Z, $urandom());
         write_reg(CSR_WIDTH_COEFF, pick_alpha());
         write_reg(CSR_CENTER_X, $urandom_range(0, 3) == 0 ? $urandom() : near_offset());
         write_reg(CSR_CENTER_Y, $urandom_range(0, 3) == 0 ? $urandom() : near_offset());
         write_reg(CSR_CENTER_Z, $urandom_range(0, 3) == 0 ? 32'h8000_0000 : near_offset());
         long_gaps = (ph % 4 != 3);
         for (int n = 0; n < 25; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_point($urandom(), $urandom(), $urandom());
            else
               send_point(cen_x + near_offset(), cen_y + near_offset(),
                          cen_z + near_offset());
         end
         wait_drained();
      end
   endtask

   initial begin
      pow_x = '0; pow_y = '0; pow_z = '0;
      alpha = 32'h0001_0000;
      cen_x = '0; cen_y = '0; cen_z = '0;
      half_roots[0] = int_sqrt(64'h8000_0000_0000_0000);
      for (int j = 1; j < EXP_TABLE_BITS; j++)
         half_roots[j] = int_sqrt(half_roots[j-1] << 32);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_points();
      test_zero_base();
      test_saturation();
      test_random_phases();
      start <= 1'b0;
      wait_drained();
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // timeout
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/gbe_pkg.sv
src/gbe_mono_step.sv
src/gbe_exp.sv
src/gaussian_basis_evaluate.sv
verif/testbench.sv
